[rtl/slr_pkg.sv]
// Shared types, codes and parse tables for the SLR(1) parser core.
`timescale 1ns / 1ps
package slr_pkg;

  localparam int StackDepthDefault = 128;

  // result status codes
  localparam logic [1:0] ST_SHIFT  = 2'd0;
  localparam logic [1:0] ST_ACCEPT = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;
  localparam logic [1:0] ST_OVFL   = 2'd3;

  // action kinds
  localparam logic [1:0] AK_NONE   = 2'd0;
  localparam logic [1:0] AK_SHIFT  = 2'd1;
  localparam logic [1:0] AK_REDUCE = 2'd2;
  localparam logic [1:0] AK_ACCEPT = 2'd3;

  // terminals
  localparam logic [4:0] TK_VT = 5'd0,  TK_NUM = 5'd1,  TK_CHR = 5'd2,  TK_BOOL = 5'd3;
  localparam logic [4:0] TK_LIT = 5'd4, TK_ID = 5'd5,   TK_IF = 5'd6,   TK_ELSE = 5'd7;
  localparam logic [4:0] TK_WHILE = 5'd8, TK_RET = 5'd9, TK_ADD = 5'd10, TK_MUL = 5'd11;
  localparam logic [4:0] TK_ASG = 5'd12, TK_CMP = 5'd13, TK_SEMI = 5'd14, TK_COMMA = 5'd15;
  localparam logic [4:0] TK_LP = 5'd16, TK_RP = 5'd17, TK_LB = 5'd18, TK_RB = 5'd19;
  localparam logic [4:0] TK_END = 5'd20;

  // nonterminals
  localparam logic [3:0] NT_CODE = 4'd0, NT_VDECL = 4'd1, NT_ASSIGN = 4'd2, NT_RHS = 4'd3;
  localparam logic [3:0] NT_EXPR = 4'd4, NT_FDECL = 4'd5, NT_ARG = 4'd6, NT_MORE = 4'd7;
  localparam logic [3:0] NT_BLOCK = 4'd8, NT_STMT = 4'd9, NT_COND = 4'd10, NT_ELSE = 4'd11;
  localparam logic [3:0] NT_RETURN = 4'd12, NT_T = 4'd13, NT_F = 4'd14, NT_C = 4'd15;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] arg;
  } action_t;

  function automatic action_t act_sh(input logic [7:0] n);
    return '{kind: AK_SHIFT, arg: n};
  endfunction

  function automatic action_t act_rd(input logic [7:0] n);
    return '{kind: AK_REDUCE, arg: n};
  endfunction

  // action table, keyed on {state, terminal}
  function automatic action_t act_lookup(input logic [6:0] st, input logic [4:0] tk);
    action_t a;
    a = '{kind: AK_NONE, arg: 8'd0};
    case ({st, tk})
      {7'd0, TK_VT}, {7'd2, TK_VT}, {7'd3, TK_VT}: a = act_sh(8'd4);
      {7'd0, TK_END}, {7'd2, TK_END}, {7'd3, TK_END}: a = act_rd(8'd3);
      {7'd1, TK_END}: a = '{kind: AK_ACCEPT, arg: 8'd0};
      {7'd4, TK_ID}: a = act_sh(8'd7);
      {7'd5, TK_END}: a = act_rd(8'd1);
      {7'd6, TK_END}: a = act_rd(8'd2);
      {7'd7, TK_SEMI}, {7'd51, TK_SEMI}: a = act_sh(8'd9);
      {7'd7, TK_ASG}, {7'd43, TK_ASG}, {7'd51, TK_ASG}: a = act_sh(8'd11);
      {7'd7, TK_LP}: a = act_sh(8'd10);
      {7'd8, TK_SEMI}: a = act_sh(8'd12);
      {7'd9, TK_VT}, {7'd9, TK_ID}, {7'd9, TK_RB}, {7'd9, TK_IF},
      {7'd9, TK_WHILE}, {7'd9, TK_RET}, {7'd9, TK_END}: a = act_rd(8'd4);
      {7'd10, TK_VT}: a = act_sh(8'd14);
      {7'd10, TK_RP}: a = act_rd(8'd20);
      {7'd11, TK_ID}, {7'd22, TK_ID}, {7'd27, TK_ID}, {7'd28, TK_ID},
      {7'd46, TK_ID}: a = act_sh(8'd23);
      {7'd11, TK_LIT}, {7'd46, TK_LIT}: a = act_sh(8'd17);
      {7'd11, TK_CHR}, {7'd46, TK_CHR}: a = act_sh(8'd18);
      {7'd11, TK_BOOL}, {7'd46, TK_BOOL}: a = act_sh(8'd19);
      {7'd11, TK_LP}, {7'd22, TK_LP}, {7'd27, TK_LP}, {7'd28, TK_LP},
      {7'd46, TK_LP}: a = act_sh(8'd22);
      {7'd11, TK_NUM}, {7'd22, TK_NUM}, {7'd27, TK_NUM}, {7'd28, TK_NUM},
      {7'd46, TK_NUM}: a = act_sh(8'd24);
      {7'd12, TK_VT}, {7'd12, TK_ID}, {7'd12, TK_RB}, {7'd12, TK_IF},
      {7'd12, TK_WHILE}, {7'd12, TK_RET}, {7'd12, TK_END}: a = act_rd(8'd5);
      {7'd13, TK_RP}: a = act_sh(8'd25);
      {7'd14, TK_ID}: a = act_sh(8'd26);
      {7'd15, TK_SEMI}: a = act_rd(8'd6);
      {7'd16, TK_SEMI}: a = act_rd(8'd7);
      {7'd16, TK_ADD}, {7'd29, TK_ADD}: a = act_sh(8'd27);
      {7'd17, TK_SEMI}: a = act_rd(8'd8);
      {7'd18, TK_SEMI}: a = act_rd(8'd9);
      {7'd19, TK_SEMI}: a = act_rd(8'd10);
      {7'd20, TK_SEMI}, {7'd20, TK_ADD}, {7'd20, TK_RP}: a = act_rd(8'd12);
      {7'd20, TK_MUL}, {7'd33, TK_MUL}: a = act_sh(8'd28);
      {7'd21, TK_SEMI}, {7'd21, TK_ADD}, {7'd21, TK_MUL}, {7'd21, TK_RP}: a = act_rd(8'd14);
      {7'd23, TK_SEMI}, {7'd23, TK_ADD}, {7'd23, TK_MUL}, {7'd23, TK_RP}: a = act_rd(8'd16);
      {7'd24, TK_SEMI}, {7'd24, TK_ADD}, {7'd24, TK_MUL}, {7'd24, TK_RP}: a = act_rd(8'd17);
      {7'd25, TK_LB}: a = act_sh(8'd30);
      {7'd26, TK_RP}, {7'd52, TK_RP}: a = act_rd(8'd22);
      {7'd26, TK_COMMA}, {7'd52, TK_COMMA}: a = act_sh(8'd32);
      {7'd29, TK_RP}: a = act_sh(8'd35);
      {7'd30, TK_VT}, {7'd37, TK_VT}, {7'd64, TK_VT}, {7'd66, TK_VT},
      {7'd73, TK_VT}: a = act_sh(8'd42);
      {7'd30, TK_ID}, {7'd37, TK_ID}, {7'd64, TK_ID}, {7'd66, TK_ID},
      {7'd73, TK_ID}: a = act_sh(8'd43);
      {7'd30, TK_IF}, {7'd37, TK_IF}, {7'd64, TK_IF}, {7'd66, TK_IF},
      {7'd73, TK_IF}: a = act_sh(8'd40);
      {7'd30, TK_WHILE}, {7'd37, TK_WHILE}, {7'd64, TK_WHILE}, {7'd66, TK_WHILE},
      {7'd73, TK_WHILE}: a = act_sh(8'd41);
      {7'd30, TK_RB}, {7'd37, TK_RB}, {7'd64, TK_RB}, {7'd66, TK_RB}, {7'd73, TK_RB},
      {7'd30, TK_RET}, {7'd37, TK_RET}, {7'd64, TK_RET}, {7'd66, TK_RET},
      {7'd73, TK_RET}: a = act_rd(8'd24);
      {7'd31, TK_RP}: a = act_rd(8'd19);
      {7'd32, TK_VT}: a = act_sh(8'd44);
      {7'd33, TK_SEMI}, {7'd33, TK_ADD}, {7'd33, TK_RP}: a = act_rd(8'd11);
      {7'd34, TK_SEMI}, {7'd34, TK_ADD}, {7'd34, TK_MUL}, {7'd34, TK_RP}: a = act_rd(8'd13);
      {7'd35, TK_SEMI}, {7'd35, TK_ADD}, {7'd35, TK_MUL}, {7'd35, TK_RP}: a = act_rd(8'd15);
      {7'd36, TK_RET}: a = act_sh(8'd46);
      {7'd38, TK_VT}, {7'd38, TK_ID}, {7'd38, TK_RB}, {7'd38, TK_IF},
      {7'd38, TK_WHILE}, {7'd38, TK_RET}: a = act_rd(8'd25);
      {7'd39, TK_SEMI}: a = act_sh(8'd48);
      {7'd40, TK_LP}: a = act_sh(8'd49);
      {7'd41, TK_LP}: a = act_sh(8'd50);
      {7'd42, TK_ID}: a = act_sh(8'd51);
      {7'd44, TK_ID}: a = act_sh(8'd52);
      {7'd45, TK_RB}: a = act_sh(8'd53);
      {7'd47, TK_RB}, {7'd47, TK_RET}: a = act_rd(8'd23);
      {7'd48, TK_VT}, {7'd48, TK_ID}, {7'd48, TK_RB}, {7'd48, TK_IF},
      {7'd48, TK_WHILE}, {7'd48, TK_RET}: a = act_rd(8'd26);
      {7'd49, TK_BOOL}, {7'd50, TK_BOOL}, {7'd62, TK_BOOL}: a = act_sh(8'd56);
      {7'd53, TK_VT}, {7'd53, TK_END}: a = act_rd(8'd18);
      {7'd54, TK_SEMI}: a = act_sh(8'd59);
      {7'd55, TK_RP}: a = act_sh(8'd60);
      {7'd56, TK_RP}: a = act_rd(8'd31);
      {7'd56, TK_CMP}: a = act_sh(8'd62);
      {7'd57, TK_RP}: a = act_sh(8'd63);
      {7'd58, TK_RP}: a = act_rd(8'd21);
      {7'd59, TK_RB}: a = act_rd(8'd34);
      {7'd60, TK_LB}: a = act_sh(8'd64);
      {7'd61, TK_RP}: a = act_rd(8'd29);
      {7'd63, TK_LB}: a = act_sh(8'd66);
      {7'd65, TK_RP}: a = act_rd(8'd30);
      {7'd67, TK_RB}: a = act_sh(8'd69);
      {7'd68, TK_RB}: a = act_sh(8'd70);
      {7'd69, TK_VT}, {7'd69, TK_ID}, {7'd69, TK_RB}, {7'd69, TK_IF},
      {7'd69, TK_WHILE}, {7'd69, TK_RET}: a = act_rd(8'd33);
      {7'd69, TK_ELSE}: a = act_sh(8'd72);
      {7'd70, TK_VT}, {7'd70, TK_ID}, {7'd70, TK_RB}, {7'd70, TK_IF},
      {7'd70, TK_WHILE}, {7'd70, TK_RET}: a = act_rd(8'd28);
      {7'd71, TK_VT}, {7'd71, TK_ID}, {7'd71, TK_RB}, {7'd71, TK_IF},
      {7'd71, TK_WHILE}, {7'd71, TK_RET}: a = act_rd(8'd27);
      {7'd72, TK_LB}: a = act_sh(8'd73);
      {7'd74, TK_RB}: a = act_sh(8'd75);
      {7'd75, TK_VT}, {7'd75, TK_ID}, {7'd75, TK_RB}, {7'd75, TK_IF},
      {7'd75, TK_WHILE}, {7'd75, TK_RET}: a = act_rd(8'd32);
      default: a = '{kind: AK_NONE, arg: 8'd0};
    endcase
    return a;
  endfunction

  // goto table, keyed on {state, nonterminal}; zero means no entry
  function automatic logic [6:0] goto_lookup(input logic [6:0] st, input logic [3:0] nt);
    logic [6:0] g;
    g = 7'd0;
    case ({st, nt})
      {7'd0, NT_CODE}: g = 7'd1;
      {7'd0, NT_VDECL}, {7'd2, NT_VDECL}, {7'd3, NT_VDECL}: g = 7'd2;
      {7'd0, NT_FDECL}, {7'd2, NT_FDECL}, {7'd3, NT_FDECL}: g = 7'd3;
      {7'd2, NT_CODE}: g = 7'd5;
      {7'd3, NT_CODE}: g = 7'd6;
      {7'd4, NT_ASSIGN}, {7'd42, NT_ASSIGN}: g = 7'd8;
      {7'd10, NT_ARG}: g = 7'd13;
      {7'd11, NT_RHS}: g = 7'd15;
      {7'd11, NT_EXPR}, {7'd46, NT_EXPR}: g = 7'd16;
      {7'd11, NT_T}, {7'd22, NT_T}, {7'd46, NT_T}: g = 7'd20;
      {7'd11, NT_F}, {7'd22, NT_F}, {7'd27, NT_F}, {7'd46, NT_F}: g = 7'd21;
      {7'd22, NT_EXPR}: g = 7'd29;
      {7'd26, NT_MORE}: g = 7'd31;
      {7'd27, NT_T}: g = 7'd33;
      {7'd28, NT_F}: g = 7'd34;
      {7'd30, NT_ASSIGN}, {7'd37, NT_ASSIGN}, {7'd64, NT_ASSIGN}, {7'd66, NT_ASSIGN},
      {7'd73, NT_ASSIGN}: g = 7'd39;
      {7'd30, NT_VDECL}, {7'd37, NT_VDECL}, {7'd64, NT_VDECL}, {7'd66, NT_VDECL},
      {7'd73, NT_VDECL}: g = 7'd38;
      {7'd30, NT_BLOCK}: g = 7'd36;
      {7'd30, NT_STMT}, {7'd37, NT_STMT}, {7'd64, NT_STMT}, {7'd66, NT_STMT},
      {7'd73, NT_STMT}: g = 7'd37;
      {7'd36, NT_RETURN}: g = 7'd45;
      {7'd37, NT_BLOCK}: g = 7'd47;
      {7'd46, NT_RHS}: g = 7'd54;
      {7'd49, NT_COND}: g = 7'd55;
      {7'd50, NT_COND}: g = 7'd57;
      {7'd52, NT_MORE}: g = 7'd58;
      {7'd56, NT_C}: g = 7'd61;
      {7'd62, NT_COND}: g = 7'd65;
      {7'd64, NT_BLOCK}: g = 7'd67;
      {7'd66, NT_BLOCK}: g = 7'd68;
      {7'd69, NT_ELSE}: g = 7'd71;
      {7'd73, NT_BLOCK}: g = 7'd74;
      default: g = 7'd0;
    endcase
    return g;
  endfunction

  // rule left-hand side and length; index 0 unused
  localparam logic [3:0] RULE_LHS [0:34] = '{4'd0,
    NT_CODE, NT_CODE, NT_CODE, NT_VDECL, NT_VDECL, NT_ASSIGN, NT_RHS, NT_RHS, NT_RHS,
    NT_RHS, NT_EXPR, NT_EXPR, NT_T, NT_T, NT_F, NT_F, NT_F, NT_FDECL, NT_ARG, NT_ARG,
    NT_MORE, NT_MORE, NT_BLOCK, NT_BLOCK, NT_STMT, NT_STMT, NT_STMT, NT_STMT, NT_COND,
    NT_C, NT_C, NT_ELSE, NT_ELSE, NT_RETURN};
  localparam logic [3:0] RULE_LEN [0:34] = '{4'd0,
    4'd2, 4'd2, 4'd0, 4'd3, 4'd3, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1,
    4'd3, 4'd1, 4'd1, 4'd9, 4'd3, 4'd0, 4'd4, 4'd0, 4'd2, 4'd0, 4'd1, 4'd2, 4'd8, 4'd7,
    4'd2, 4'd2, 4'd0, 4'd4, 4'd0, 4'd3};

  function automatic logic [3:0] rule_len(input logic [7:0] r);
    return (r <= 8'd34) ? RULE_LEN[r[5:0]] : 4'd0;
  endfunction

  function automatic logic [3:0] rule_lhs(input logic [7:0] r);
    return (r <= 8'd34) ? RULE_LHS[r[5:0]] : 4'd0;
  endfunction

endpackage

[rtl/slr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module slr_ram #(
  parameter int Width = 7,
  parameter int Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [0:Depth-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/slr_shift_reduce_parser_core.sv]
// Top level: SLR(1) shift-reduce parser sequencer around the state stack RAM.
//
// One token per transfer, one result per token. A token is taken in from
// idle, then gets its shift, accept or reject decision in the action state;
// each reduction before it adds an action lookup, then the stack RAM read
// of the exposed state and the goto push. Every reduction waits on the
// stack RAM's registered read. The top of stack is also held in a register,
// so shifts need no RAM read. The bottom entry is never written and reads as
// state 0, so no clearing pass is needed after reset. A finished result sits
// in an output register, and the next token is taken while it waits.
`timescale 1ns / 1ps
module slr_shift_reduce_parser_core #(
  parameter int STACK_DEPTH = slr_pkg::StackDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [4:0] token_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [6:0] top_state,
  output logic [7:0] stack_depth,
  output logic [7:0] reduce_count
);

  localparam int SpW      = $clog2(STACK_DEPTH);
  localparam int RedLimit = 4 * STACK_DEPTH;
  localparam int RedW     = $clog2(RedLimit + 2);
  localparam logic [SpW-1:0] SpMax = SpW'(STACK_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ACT  = 3'b010,
    S_GO   = 3'b100
  } state_t;

  state_t           state;
  logic [SpW-1:0]   sp;
  logic [6:0]       top;
  logic [4:0]       tok;
  logic [7:0]       count;
  logic [RedW-1:0]  nred;
  logic [3:0]       lhs;

  slr_pkg::action_t act;
  logic [3:0]       len;
  logic [SpW-1:0]   sp_inc;
  logic [SpW-1:0]   sp_pop;
  logic [6:0]       below;
  logic [6:0]       nxt;
  logic [7:0]       count_inc;
  logic             slot_free;
  logic             lim_hit;
  logic             ram_we;
  logic [SpW-1:0]   ram_raddr;
  logic [6:0]       ram_wdata;
  logic [6:0]       ram_rdata;
  logic [7:0]       depth_shift;

  // decode of the current top of stack and token
  always_comb begin
    act         = slr_pkg::act_lookup(top, tok);
    len         = slr_pkg::rule_len(act.arg);
    sp_inc      = sp + 1'b1;
    sp_pop      = sp - SpW'(len);
    below       = (sp == '0) ? 7'd0 : ram_rdata;
    nxt         = slr_pkg::goto_lookup(below, lhs);
    count_inc   = (count == 8'hFF) ? count : count + 8'd1;
    slot_free   = !out_valid || !out_stall;
    lim_hit     = (nred == RedW'(RedLimit));
    depth_shift = 8'({1'b0, sp} + (SpW + 1)'(2));
  end

  // stack RAM ports: pushes go one above the top, reads follow the pointer, or the popped pointer in action lookup
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = nxt;
    ram_raddr = (state == S_ACT) ? sp_pop : sp;
    case (state)
      S_ACT: begin
        ram_wdata = act.arg[6:0];
        ram_we    = (act.kind == slr_pkg::AK_SHIFT) && (sp != SpMax) && slot_free;
      end
      S_GO: begin
        ram_we = (nxt != 7'd0) && (sp != SpMax);
      end
      default: ram_we = 1'b0;
    endcase
  end

  slr_ram #(
    .Width(7),
    .Depth(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(sp_inc),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_stall = (state != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      top       <= 7'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            tok   <= token_code;
            count <= 8'd0;
            nred  <= '0;
            state <= S_ACT;
          end
        end
        S_ACT: begin
          if (act.kind == slr_pkg::AK_REDUCE && act.arg >= 8'd1 && act.arg <= 8'd34
              && {1'b0, len} <= (SpW + 1)'(sp)) begin
            sp    <= sp_pop;
            lhs   <= slr_pkg::rule_lhs(act.arg);
            state <= S_GO;
          end else if (slot_free) begin
            out_valid    <= 1'b1;
            reduce_count <= count;
            state        <= S_IDLE;
            if (act.kind == slr_pkg::AK_SHIFT && sp != SpMax) begin
              sp          <= sp_inc;
              top         <= act.arg[6:0];
              status      <= slr_pkg::ST_SHIFT;
              top_state   <= act.arg[6:0];
              stack_depth <= depth_shift;
            end else begin
              sp          <= '0;
              top         <= 7'd0;
              top_state   <= 7'd0;
              stack_depth <= 8'd1;
              if (act.kind == slr_pkg::AK_SHIFT) begin
                status <= slr_pkg::ST_OVFL;
              end else if (act.kind == slr_pkg::AK_ACCEPT) begin
                status <= slr_pkg::ST_ACCEPT;
              end else begin
                status <= slr_pkg::ST_REJECT;
              end
            end
          end
        end
        S_GO: begin
          if (nxt != 7'd0 && sp != SpMax && !lim_hit) begin
            sp    <= sp_inc;
            top   <= nxt;
            count <= count_inc;
            nred  <= nred + 1'b1;
            state <= S_ACT;
          end else if (slot_free) begin
            // error ends the token; the stack drops back to state 0
            out_valid    <= 1'b1;
            sp           <= '0;
            top          <= 7'd0;
            top_state    <= 7'd0;
            stack_depth  <= 8'd1;
            state        <= S_IDLE;
            reduce_count <= (nxt != 7'd0 && sp != SpMax) ? count_inc : count;
            status       <= (nxt != 7'd0 && sp == SpMax) ? slr_pkg::ST_OVFL
                                                         : slr_pkg::ST_REJECT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the bottom entry must never be overwritten
  a_no_bottom_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> sp_inc != '0)
    else $error("stack write to bottom entry");

  // any non-shift result leaves only state 0 on the stack
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != slr_pkg::ST_SHIFT |-> top_state == 7'd0 && stack_depth == 8'd1)
    else $error("stack not cleared after end of parse");

  // a taken token goes straight to action lookup
  a_accept_to_act: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_ACT)
    else $error("token taken without lookup");

  // a goto step only follows a reduce decision or a held goto step
  a_go_origin: assert property (@(posedge clk) disable iff (rst)
    state == S_GO |-> $past(state) == S_ACT || $past(state) == S_GO)
    else $error("goto step without reduction");

  // registered top of stack matches a pushed shift
  a_shift_top: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && status == slr_pkg::ST_SHIFT |-> top_state == top)
    else $error("shift result disagrees with top of stack");

endmodule
